FILE: hw/rtl/hfpc_pkg.sv
// Shared types and constants for the hashed flow packet counter.
`timescale 1ns / 1ps
package hfpc_pkg;

  localparam int unsigned KEY_W = 64;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned TOT_W = 14;
  localparam int unsigned STEP_W = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [TOT_W-1:0] TOT_MAX = '1;
  localparam logic [STEP_W-1:0] STEP_LAST = '1;

  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] count;
    logic [KEY_W-1:0] key;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic load;
    logic div_step;
    logic rd;
    logic clr;
    logic upd;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

FILE: hw/rtl/hfpc_ram.sv
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module hfpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/hfpc_ctrl.sv
// Controller state machine: clear pass, remainder steps, row read and update.
`timescale 1ns / 1ps
module hfpc_ctrl
  import hfpc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_WT,
    ST_UPD
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLR:  if (sts_i.clr_last) state_d = ST_IDLE;
      ST_IDLE: if (in_valid_i) state_d = ST_DIV;
      ST_DIV:  if (sts_i.div_last) state_d = ST_RD;
      ST_RD:   state_d = ST_WT;
      ST_WT:   state_d = ST_UPD;
      ST_UPD:  if (sts_i.out_free) state_d = ST_IDLE;
      default: state_d = ST_CLR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign cmd_o.load     = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.div_step = (state_q == ST_DIV);
  assign cmd_o.rd       = (state_q == ST_RD);
  assign cmd_o.clr      = (state_q == ST_CLR);
  assign cmd_o.upd      = (state_q == ST_UPD) && sts_i.out_free;

endmodule

FILE: hw/rtl/hfpc_dp.sv
// Datapath: bucket remainder, way compare, row update and result register.
`timescale 1ns / 1ps
module hfpc_dp
  import hfpc_pkg::*;
#(
  parameter int unsigned BUCKETS = 2048,
  parameter int unsigned WAYS    = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cmd_t                       cmd_i,
  output sts_t                       sts_o,
  input  logic [KEY_W-1:0]           key_i,
  output logic                       we_o,
  output logic [$clog2(BUCKETS)-1:0] waddr_o,
  output logic [WAYS*ENTRY_W-1:0]    wdata_o,
  output logic                       re_o,
  output logic [$clog2(BUCKETS)-1:0] raddr_o,
  input  logic [WAYS*ENTRY_W-1:0]    rdata_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [CNT_W-1:0]           count_o,
  output logic                       new_flow_o,
  output logic                       full_o,
  output logic [TOT_W-1:0]           total_o
);

  localparam int unsigned IW   = $clog2(BUCKETS);
  localparam int unsigned CH_W = 16;
  localparam int unsigned X_W  = 2 * CH_W;
  localparam int unsigned PW   = 2 * X_W + 1;
  localparam int unsigned SH   = X_W + IW;
  localparam longint unsigned RECIP_L = (64'd1 << SH) / 64'(BUCKETS);
  localparam logic [X_W:0]   RECIP = (X_W+1)'(RECIP_L);
  localparam logic [X_W-1:0] BK = X_W'(BUCKETS);
  localparam logic [IW-1:0]  CLR_LAST = IW'(BUCKETS - 1);

  logic [KEY_W-1:0]  key_q, mag_q, mag_d;
  logic [IW-1:0]     rem_q, rem_d;
  logic [STEP_W-1:0] step_q;
  logic [IW-1:0]     clr_q;
  logic [X_W-1:0]    x, quot_q, quot_d, qb, diff;
  logic [PW-1:0]     prod;

  logic              valid_q;
  logic [CNT_W-1:0]  count_q;
  logic              new_q, full_q;
  logic [TOT_W-1:0]  total_q;

  entry_t [WAYS-1:0] row, row_new;
  logic              hit, free;
  logic [CNT_W-1:0]  cnt_new;

  assign mag_d = key_i[KEY_W-1] ? (~key_i + KEY_W'(1)) : key_i;

  // one 16-bit digit per two steps: quotient estimate, then subtract and correct
  assign x      = {CH_W'(rem_q), mag_q[KEY_W-1 -: CH_W]};
  assign prod   = PW'(x) * PW'(RECIP);
  assign quot_d = X_W'(prod >> SH);
  assign qb     = quot_q * BK;
  assign diff   = x - qb;
  assign rem_d  = (diff >= BK) ? IW'(diff - BK) : IW'(diff);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= key_i;
      mag_q <= mag_d;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      if (!step_q[0]) begin
        quot_q <= quot_d;
      end else begin
        rem_q <= rem_d;
        mag_q <= {mag_q[KEY_W-CH_W-1:0], CH_W'(0)};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      clr_q   <= '0;
      valid_q <= 1'b0;
      total_q <= '0;
    end else begin
      if (cmd_i.load) begin
        step_q <= '0;
      end else if (cmd_i.div_step) begin
        step_q <= step_q + STEP_W'(1);
      end
      if (cmd_i.clr) begin
        clr_q <= clr_q + IW'(1);
      end
      if (cmd_i.upd) begin
        valid_q <= 1'b1;
        if (!hit && free && total_q != TOT_MAX) begin
          total_q <= total_q + TOT_W'(1);
        end
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    row     = rdata_i;
    row_new = row;
    hit     = 1'b0;
    free    = 1'b0;
    cnt_new = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (row[w].valid) begin
        if (!hit && row[w].key == key_q) begin
          hit = 1'b1;
          cnt_new = (row[w].count == CNT_MAX) ? CNT_MAX : row[w].count + CNT_W'(1);
          row_new[w].count = cnt_new;
        end
      end
    end
    if (!hit) begin
      for (int w = 0; w < WAYS; w++) begin
        if (!row[w].valid && !free) begin
          free = 1'b1;
          cnt_new = CNT_W'(1);
          row_new[w].valid = 1'b1;
          row_new[w].key   = key_q;
          row_new[w].count = CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      count_q <= cnt_new;
      new_q   <= !hit && free;
      full_q  <= !hit && !free;
    end
  end

  assign we_o    = cmd_i.clr || (cmd_i.upd && (hit || free));
  assign waddr_o = cmd_i.clr ? clr_q : rem_q;
  assign wdata_o = cmd_i.clr ? '0 : row_new;
  assign re_o    = cmd_i.rd;
  assign raddr_o = rem_q;

  assign sts_o.div_last = (step_q == STEP_LAST);
  assign sts_o.clr_last = (clr_q == CLR_LAST);
  assign sts_o.out_free = !valid_q || out_ready_i;

  assign out_valid_o = valid_q;
  assign count_o     = count_q;
  assign new_flow_o  = new_q;
  assign full_o      = full_q;
  assign total_o     = total_q;

endmodule

FILE: hw/rtl/hashed_flow_packet_counter.sv
// Top level of the hashed flow packet counter.
`timescale 1ns / 1ps
// Counts packets per flow in a table of BUCKETS rows by WAYS slots, one row a RAM
// word. After reset a clearing pass writes one row per cycle before the first key
// is taken. Each key then passes through acceptance, the remainder
// |key| mod BUCKETS (four 16-bit digits, each a reciprocal quotient estimate and
// a corrected subtract), the row read, the registered read data, and compare
// and write-back. A result waits in the output register; a new key is accepted
// meanwhile, and its update holds until the earlier result is taken.
module hashed_flow_packet_counter
  import hfpc_pkg::*;
#(
  parameter int unsigned BUCKETS = 2048,
  parameter int unsigned WAYS    = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,  // flow_key[63:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o   // packet_count[31:0], new_flow, bucket_full,
                                       // flow_total[13:0]
);

  localparam int unsigned IW = $clog2(BUCKETS);
  localparam int unsigned RWID = WAYS * ENTRY_W;

  cmd_t            cmd;
  sts_t            sts;
  logic            we, re;
  logic [IW-1:0]   waddr, raddr;
  logic [RWID-1:0] wdata, rdata;
  logic [CNT_W-1:0] count;
  logic            new_flow, full;
  logic [TOT_W-1:0] total;

  hfpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hfpc_dp #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .key_i       (s_axis_tdata_i),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .re_o        (re),
    .raddr_o     (raddr),
    .rdata_i     (rdata),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .count_o     (count),
    .new_flow_o  (new_flow),
    .full_o      (full),
    .total_o     (total)
  );

  hfpc_ram #(
    .WIDTH (RWID),
    .DEPTH (BUCKETS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign m_axis_tdata_o = {total, full, new_flow, count};

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for hashed_flow_packet_counter: stream traffic, flow table predictor.
`timescale 1ns / 1ps
module tb_top
  import hfpc_pkg::*;
();

  localparam int unsigned BUCKETS = 2048;
  localparam int unsigned WAYS    = 4;
  localparam int unsigned SLOTS   = BUCKETS * WAYS;
  localparam int unsigned STALL_LIMIT = 6000;

  typedef struct packed {
    logic [TOT_W-1:0] flow_total;
    logic             bucket_full;
    logic             new_flow;
    logic [CNT_W-1:0] packet_count;
  } flow_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [47:0] m_axis_tdata_o;

  hashed_flow_packet_counter #(
    .BUCKETS(BUCKETS),
    .WAYS   (WAYS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // flow table mirror
  bit               slot_valid [SLOTS];
  logic [KEY_W-1:0] slot_key   [SLOTS];
  logic [CNT_W-1:0] slot_count [SLOTS];
  logic [TOT_W-1:0] flows_seen;

  flow_result_t pending_results[$];
  int unsigned  error_count = 0;
  int unsigned  keys_sent;
  int unsigned  results_checked = 0;
  int unsigned  full_hits = 0;
  int unsigned  new_flows = 0;
  bit           hold_req;
  int unsigned  quiet_cycles = 0;
  bit           idle_on;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic flow_result_t count_packet(logic [KEY_W-1:0] key);
    flow_result_t res;
    logic [KEY_W-1:0] mag;
    int unsigned base;
    int hit;
    int freeway;
    res = '0;
    hit = -1;
    freeway = -1;
    mag = key[KEY_W-1] ? (~key + 1'b1) : key;
    base = int'(mag % BUCKETS) * WAYS;
    for (int w = 0; w < WAYS; w++) begin
      if (slot_valid[base+w]) begin
        if (hit < 0 && slot_key[base+w] == key) hit = w;
      end else if (freeway < 0) begin
        freeway = w;
      end
    end
    if (hit >= 0) begin
      if (slot_count[base+hit] != CNT_MAX) slot_count[base+hit]++;
      res.packet_count = slot_count[base+hit];
    end else if (freeway >= 0) begin
      slot_valid[base+freeway] = 1'b1;
      slot_key[base+freeway]   = key;
      slot_count[base+freeway] = 1;
      res.packet_count = 1;
      res.new_flow = 1'b1;
      if (flows_seen != TOT_MAX) flows_seen++;
    end else begin
      res.bucket_full = 1'b1;
    end
    res.flow_total = flows_seen;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("ERROR %0t: %s got %0h expected %0h", $time, what, got, want);
    error_count++;
  endtask

  task automatic send_key(logic [KEY_W-1:0] key);
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = key;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_results.push_back(count_packet(key));
    keys_sent++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      s_axis_tvalid_i = 1'b0;
      repeat ($urandom_range(1, 17) - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    wait (pending_results.size() == 0);
  endtask

  function automatic logic [KEY_W-1:0] key_in_bucket(int unsigned b, int unsigned mult, bit neg);
    logic [KEY_W-1:0] mag;
    mag = KEY_W'(b) + KEY_W'(BUCKETS) * KEY_W'(mult);
    return neg ? (~mag + 1'b1) : mag;
  endfunction

  task automatic test_extremes();
    send_key(64'd0);
    send_key(64'd1);
    send_key('1);
    send_key(64'h7fff_ffff_ffff_ffff);
    send_key(64'h8000_0000_0000_0000);
    send_key(64'd2048);
    send_key(-64'sd2048);
    send_key(64'h8000_0000_0000_0000);
    send_key(64'd1);
    send_key(64'haaaa_aaaa_aaaa_aaaa);
    send_key(64'h5555_5555_5555_5555);
    drain_results();
  endtask

  task automatic test_full_bucket();
    for (int i = 0; i < 6; i++) send_key(key_in_bucket(5, i / 2, i[0]));
    send_key(key_in_bucket(5, 0, 1'b0));
    send_key(key_in_bucket(5, 2, 1'b0));
    send_key(key_in_bucket(5, 1, 1'b1));
    drain_results();
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 8; i++) send_key(key_in_bucket(9, i % 3, 1'b0));
    drain_results();
  endtask

  task automatic test_random(int unsigned n);
    logic [KEY_W-1:0] flow_pool[$];
    int unsigned hot_buckets[6] = '{0, 3, 77, 1023, 1500, 2047};
    for (int i = 0; i < 30; i++)
      flow_pool.push_back(key_in_bucket(hot_buckets[$urandom_range(0, 5)],
                                        $urandom_range(0, 5), 1'($urandom_range(0, 1))));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 7) send_key(flow_pool[$urandom_range(0, 29)]);
      else send_key({$urandom, $urandom});
    end
    drain_results();
  endtask

  // result checker
  always @(posedge clk_i) begin
    flow_result_t got;
    flow_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transfer", m_axis_tdata_o, 0);
      end else begin
        want = pending_results.pop_front();
        if (got.packet_count !== want.packet_count)
          report_mismatch("packet_count", got.packet_count, want.packet_count);
        if (got.new_flow !== want.new_flow)
          report_mismatch("new_flow", got.new_flow, want.new_flow);
        if (got.bucket_full !== want.bucket_full)
          report_mismatch("bucket_full", got.bucket_full, want.bucket_full);
        if (got.flow_total !== want.flow_total)
          report_mismatch("flow_total", got.flow_total, want.flow_total);
        full_hits += want.bucket_full;
        new_flows += want.new_flow;
        results_checked++;
      end
    end
  end

  // receiver stalls
  initial begin
    int unsigned stall;
    int unsigned hold_cycles;
    bit          hold_taken;
    stall = 0;
    hold_cycles = 0;
    hold_taken = 1'b0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_cycles = 400;
      end
      if (hold_cycles > 0) begin
        m_axis_tready_i = 1'b0;
        hold_cycles--;
      end else if (stall > 0) begin
        m_axis_tready_i = 1'b0;
        stall--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready_i = 1'b0;
        stall = $urandom_range(1, 17) - 1;
      end else begin
        m_axis_tready_i = 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("watchdog expired, %0d results outstanding", pending_results.size());
      $display("hashed_flow_packet_counter verification failed");
      $finish;
    end
  end

  initial begin
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    rst_ni          = 1'b0;
    keys_sent       = 0;
    hold_req        = 1'b0;
    flows_seen      = '0;
    idle_on         = 1'b1;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_extremes();
    test_full_bucket();
    test_backpressure();
    test_random(900);
    idle_on = 1'b0;
    test_random(180);

    repeat (100) @(posedge clk_i);
    $display("sent %0d keys, checked %0d results", keys_sent, results_checked);
    $display("new flows %0d, full-bucket misses %0d, final flow total %0d",
             new_flows, full_hits, flows_seen);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("hashed_flow_packet_counter verification clean");
    end else begin
      $display("hashed_flow_packet_counter verification failed");
    end
    $finish;
  end

endmodule

FILE: hashed_flow_packet_counter.f
hw/rtl/hfpc_pkg.sv
hw/rtl/hfpc_ram.sv
hw/rtl/hfpc_ctrl.sv
hw/rtl/hfpc_dp.sv
hw/rtl/hashed_flow_packet_counter.sv
tb/tb_top.sv
